@@ hw/rtl/bcwf_pkg.sv @@
// ----------------------------------------------------------------------------
// bcwf_pkg
// Shared constants, codes, control structs and the byte-to-base decoder of
// the base composition window filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcwf_pkg;

    localparam int MAX_WINDOW_DEF    = 1024;
    localparam int POSITION_BITS_DEF = 32;
    localparam int REG_W             = 11;
    localparam int CFG_ADDR_W        = 3;
    localparam int NUM_BASES         = 4;
    localparam int OUT_W             = 32;
    localparam int OUT_FIFO_DEPTH    = 8;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SCORE_THRESHOLD = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_QUERY_COUNT_A   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_QUERY_COUNT_C   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_QUERY_COUNT_G   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_QUERY_COUNT_T   = 3'd5;

    // ascii bytes of the four bases
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    // control of an item entering the count stage
    typedef struct packed {
        logic valid;
        logic eos;
        logic remove;
        logic score_en;
    } t_s1_ctl;

    // control of an item entering the region stage
    typedef struct packed {
        logic valid;
        logic eos;
        logic score_en;
        logic hit;
    } t_s3_ctl;

    function automatic logic [1:0] base_code(input logic [7:0] ch);
        logic [1:0] code;
        unique case (ch)
            CHAR_A:  code = CODE_A;
            CHAR_C:  code = CODE_C;
            CHAR_G:  code = CODE_G;
            CHAR_T:  code = CODE_T;
            default: code = CODE_A;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bcwf_front.sv @@
// ----------------------------------------------------------------------------
// bcwf_front
// Input stage: decodes the byte, keeps position, fill count and the base
// history memory, and reads the code that leaves the window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcwf_front import bcwf_pkg::*; #(
    parameter int MAX_WINDOW    = MAX_WINDOW_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    localparam int LEN_W        = $clog2(MAX_WINDOW + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire logic [7:0]               i_base_char,
    input  wire logic                     i_eos,
    input  wire logic [LEN_W-1:0]         i_len,
    output t_s1_ctl                       o_s1,
    output logic [1:0]                    o_s1_code,
    output logic [1:0]                    o_old_code,
    output logic [POSITION_BITS-1:0]      o_s1_ws
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int EW = LEN_W + 1;

    logic [1:0]               r_hist [MAX_WINDOW];
    logic [1:0]               r_rd;
    logic [AW-1:0]            r_wp;
    logic [LEN_W-1:0]         r_fill;
    logic [POSITION_BITS-1:0] r_pos;
    t_s1_ctl                  r_s1;
    logic [1:0]               r_code;
    logic [POSITION_BITS-1:0] r_ws;

    logic [1:0]               code;
    logic [LEN_W-1:0]         fill_nxt;
    logic [AW-1:0]            wp_nxt;
    logic [EW-1:0]            wp_e;
    logic [EW-1:0]            len_e;
    logic [EW-1:0]            rd_e;
    logic [AW-1:0]            rd_addr;
    logic [POSITION_BITS-1:0] ws;

    always_comb begin
        code     = base_code(i_base_char);
        fill_nxt = (r_fill < LEN_W'(MAX_WINDOW)) ? r_fill + 1'b1 : r_fill;
        wp_nxt   = (r_wp == AW'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;
        // oldest entry of the window, modulo the history depth
        wp_e     = EW'(r_wp);
        len_e    = EW'(i_len);
        rd_e     = (wp_e >= len_e) ? wp_e - len_e : wp_e + EW'(MAX_WINDOW) - len_e;
        rd_addr  = rd_e[AW-1:0];
        ws       = r_pos + POSITION_BITS'(1) - POSITION_BITS'(i_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= '0;
            r_wp   <= '0;
            r_fill <= '0;
            r_pos  <= '0;
        end else begin
            r_s1.valid <= i_accept;
            if (i_accept) begin
                r_s1.eos      <= i_eos;
                r_s1.remove   <= (r_fill >= i_len);
                r_s1.score_en <= (fill_nxt >= i_len);
                r_wp          <= wp_nxt;
                r_fill        <= i_eos ? '0 : fill_nxt;
                r_pos         <= i_eos ? '0 : r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_code <= code;
            r_ws   <= ws;
        end
    end

    // read-first: at full window length the read hits the entry written now
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hist[r_wp] <= code;
            r_rd         <= r_hist[rd_addr];
        end
    end

    assign o_s1       = r_s1;
    assign o_s1_code  = r_code;
    assign o_old_code = r_rd;
    assign o_s1_ws    = r_ws;

    a_eos_restarts_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_eos |=> r_fill == '0 && r_pos == '0)
        else $error("stream state not cleared after end of stream");

endmodule

`default_nettype wire

@@ hw/rtl/bcwf_score.sv @@
// ----------------------------------------------------------------------------
// bcwf_score
// Count stage and score stage: updates the four window counts, then sums
// min(window count, query count) and compares against the threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcwf_score import bcwf_pkg::*; #(
    parameter int MAX_WINDOW    = MAX_WINDOW_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire t_s1_ctl                           i_s1,
    input  wire logic [1:0]                        i_code,
    input  wire logic [1:0]                        i_old_code,
    input  wire logic [POSITION_BITS-1:0]          i_ws,
    input  wire logic [NUM_BASES-1:0][REG_W-1:0]   i_query,
    input  wire logic [REG_W-1:0]                  i_threshold,
    output logic                                   o_v2,
    output t_s3_ctl                                o_s3,
    output logic [POSITION_BITS-1:0]               o_s3_ws
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int MW    = (CNT_W > REG_W) ? CNT_W : REG_W;
    localparam int SW    = MW + 2;

    logic [NUM_BASES-1:0][CNT_W-1:0] r_counts;
    logic                            r_clr;
    logic                            r_v2;
    logic                            r_eos2;
    logic                            r_sen2;
    logic [POSITION_BITS-1:0]        r_ws2;
    t_s3_ctl                         r_s3;
    logic [POSITION_BITS-1:0]        r_ws3;

    logic [NUM_BASES-1:0][CNT_W-1:0] n_counts;
    logic [NUM_BASES-1:0][MW-1:0]    mins;
    logic [SW-1:0]                   score;
    logic [CNT_W-1:0]                base;
    logic                            dec;
    logic                            inc;

    always_comb begin
        for (int k = 0; k < NUM_BASES; k++) begin
            // counts restart from zero after an end of stream
            base = r_clr ? '0 : r_counts[k];
            dec  = i_s1.remove && (i_old_code == 2'(k)) && (base != '0);
            inc  = (i_code == 2'(k));
            n_counts[k] = base + CNT_W'(inc) - CNT_W'(dec);
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_BASES; k++) begin
            mins[k] = (MW'(r_counts[k]) < MW'(i_query[k])) ? MW'(r_counts[k])
                                                             : MW'(i_query[k]);
        end
        score = (SW'(mins[0]) + SW'(mins[1])) + (SW'(mins[2]) + SW'(mins[3]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= 1'b1;
            r_v2  <= 1'b0;
            r_s3  <= '0;
        end else begin
            r_v2       <= i_s1.valid;
            r_s3.valid <= r_v2;
            if (i_s1.valid) begin
                r_clr <= i_s1.eos;
            end
            if (r_v2) begin
                r_s3.eos      <= r_eos2;
                r_s3.score_en <= r_sen2;
                r_s3.hit      <= (score >= SW'(i_threshold));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1.valid) begin
            r_counts <= n_counts;
            r_eos2   <= i_s1.eos;
            r_sen2   <= i_s1.score_en;
            r_ws2    <= i_ws;
        end
        if (r_v2) begin
            r_ws3 <= r_ws2;
        end
    end

    assign o_v2    = r_v2;
    assign o_s3    = r_s3;
    assign o_s3_ws = r_ws3;

endmodule

`default_nettype wire

@@ hw/rtl/bcwf_region.sv @@
// ----------------------------------------------------------------------------
// bcwf_region
// Region stage: merges hit windows into regions, closes them on a gap or at
// end of stream, and queues the results in a small output fifo.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcwf_region import bcwf_pkg::*; #(
    parameter int MAX_WINDOW    = MAX_WINDOW_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    localparam int LEN_W        = $clog2(MAX_WINDOW + 1),
    localparam int FCW          = $clog2(OUT_FIFO_DEPTH + 1)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_s3_ctl                   i_s3,
    input  wire logic [POSITION_BITS-1:0]  i_ws,
    input  wire logic [LEN_W-1:0]          i_len,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [2*OUT_W-1:0]             m_axis_tdata,
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast,
    output logic [FCW-1:0]                 o_count
);

    localparam int GW  = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;
    localparam int XW  = (POSITION_BITS > OUT_W) ? POSITION_BITS : OUT_W;
    localparam int FAW = $clog2(OUT_FIFO_DEPTH);

    logic                     r_open;
    logic [POSITION_BITS-1:0] r_start;
    logic [POSITION_BITS-1:0] r_end;

    logic [OUT_W-1:0]         r_f_start [OUT_FIFO_DEPTH];
    logic [OUT_W-1:0]         r_f_end   [OUT_FIFO_DEPTH];
    logic                     r_f_valid [OUT_FIFO_DEPTH];
    logic                     r_f_done  [OUT_FIFO_DEPTH];
    logic [FAW-1:0]           r_wr;
    logic [FAW-1:0]           r_rd;
    logic [FCW-1:0]           r_count;

    logic                     n_open;
    logic [POSITION_BITS-1:0] n_start;
    logic [POSITION_BITS-1:0] n_end;
    logic [POSITION_BITS-1:0] gap;
    logic                     closed;
    logic                     res_region;
    logic                     push;
    logic                     pop;
    logic [XW-1:0]            start_x;
    logic [XW-1:0]            end_x;

    always_comb begin
        n_open  = r_open;
        n_start = r_start;
        n_end   = r_end;
        closed  = 1'b0;
        gap     = i_ws - r_end;
        if (i_s3.valid && i_s3.score_en) begin
            if (i_s3.hit) begin
                if (!r_open) begin
                    n_open  = 1'b1;
                    n_start = i_ws;
                    n_end   = i_ws + 1'b1;
                end else begin
                    n_end = i_ws;
                end
            end else if (r_open && (GW'(gap) > GW'(i_len))) begin
                closed = 1'b1;
                n_open = 1'b0;
            end
        end
        // at end of stream a still open region is reported as well
        res_region = closed || (i_s3.eos && n_open);
        push       = i_s3.valid && (closed || i_s3.eos);
        pop        = m_axis_tvalid && m_axis_tready;
        start_x    = res_region ? XW'(n_start) : '0;
        end_x      = res_region ? XW'(n_end) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_start <= '0;
            r_end   <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_s3.valid && i_s3.eos) begin
                r_open  <= 1'b0;
                r_start <= '0;
                r_end   <= '0;
            end else begin
                r_open  <= n_open;
                r_start <= n_start;
                r_end   <= n_end;
            end
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + FCW'(push) - FCW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_f_start[r_wr] <= start_x[OUT_W-1:0];
            r_f_end[r_wr]   <= end_x[OUT_W-1:0];
            r_f_valid[r_wr] <= res_region;
            r_f_done[r_wr]  <= i_s3.eos;
        end
    end

    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {r_f_end[r_rd], r_f_start[r_rd]};
    assign m_axis_tuser  = r_f_valid[r_rd];
    assign m_axis_tlast  = r_f_done[r_rd];
    assign o_count       = r_count;

    a_fifo_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |-> r_count < FCW'(OUT_FIFO_DEPTH))
        else $error("result fifo overflow");

    a_eos_closes_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s3.valid && i_s3.eos |=> !r_open && r_end == '0)
        else $error("region state kept across end of stream");

    a_empty_result_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !res_region |-> i_s3.eos)
        else $error("result without region outside end of stream");

endmodule

`default_nettype wire

@@ hw/rtl/base_composition_window_filter.sv @@
// ----------------------------------------------------------------------------
// base_composition_window_filter
// Sliding-window base composition filter: scores every window of the byte
// stream against the query composition and reports merged hit regions.
// ----------------------------------------------------------------------------
// path: a result is offered once the byte that causes it has passed the history
//   read, count update, score and region merge, each of them registered
// throughput: one byte per cycle unless the input stalls for lack of fifo room; the
//   history memory takes one write and one read per byte, results wait in an 8-entry output fifo
// reset: synchronous, active low; clears counts, position, region and fifo;
//   the base history memory is not cleared and needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module base_composition_window_filter import bcwf_pkg::*; #(
    parameter int MAX_WINDOW    = MAX_WINDOW_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [REG_W-1:0]      i_cfg_data,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] base_char
    input  wire logic                  s_axis_tlast,   // end_of_stream
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [2*OUT_W-1:0]         m_axis_tdata,   // [31:0] region_start, [63:32] region_end
    output logic                       m_axis_tuser,   // region_valid
    output logic                       m_axis_tlast    // stream_done
);

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int LW0   = (LEN_W > REG_W) ? LEN_W : REG_W;
    localparam int FCW   = $clog2(OUT_FIFO_DEPTH + 1);

    logic [LEN_W-1:0]                r_len;
    logic [REG_W-1:0]                r_threshold;
    logic [NUM_BASES-1:0][REG_W-1:0] r_query;

    logic [LW0-1:0]                  wl_e;
    logic [LEN_W-1:0]                n_len;
    logic                            accept;
    logic [FCW:0]                    pending;

    t_s1_ctl                         s1;
    logic [1:0]                      s1_code;
    logic [1:0]                      old_code;
    logic [POSITION_BITS-1:0]        s1_ws;
    logic                            v2;
    t_s3_ctl                         s3;
    logic [POSITION_BITS-1:0]        s3_ws;
    logic [FCW-1:0]                  fifo_count;

    // zero length counts as one, lengths above the history depth saturate
    always_comb begin
        wl_e  = LW0'(i_cfg_data);
        n_len = (wl_e == '0) ? LEN_W'(1)
              : (wl_e > LW0'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW)
              : LEN_W'(wl_e);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_W'(1);
            r_threshold <= '0;
            r_query     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_WINDOW_LENGTH:   r_len       <= n_len;
                REG_SCORE_THRESHOLD: r_threshold <= i_cfg_data;
                REG_QUERY_COUNT_A:   r_query[0]  <= i_cfg_data;
                REG_QUERY_COUNT_C:   r_query[1]  <= i_cfg_data;
                REG_QUERY_COUNT_G:   r_query[2]  <= i_cfg_data;
                REG_QUERY_COUNT_T:   r_query[3]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // every item in flight may still claim a fifo slot
    always_comb begin
        pending = (FCW + 1)'(fifo_count) + (FCW + 1)'(s1.valid)
                + (FCW + 1)'(v2) + (FCW + 1)'(s3.valid);
        s_axis_tready = (pending < (FCW + 1)'(OUT_FIFO_DEPTH));
        accept = s_axis_tvalid && s_axis_tready;
    end

    bcwf_front #(
        .MAX_WINDOW    (MAX_WINDOW),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_base_char (s_axis_tdata),
        .i_eos       (s_axis_tlast),
        .i_len       (r_len),
        .o_s1        (s1),
        .o_s1_code   (s1_code),
        .o_old_code  (old_code),
        .o_s1_ws     (s1_ws)
    );

    bcwf_score #(
        .MAX_WINDOW    (MAX_WINDOW),
        .POSITION_BITS (POSITION_BITS)
    ) u_score (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1        (s1),
        .i_code      (s1_code),
        .i_old_code  (old_code),
        .i_ws        (s1_ws),
        .i_query     (r_query),
        .i_threshold (r_threshold),
        .o_v2        (v2),
        .o_s3        (s3),
        .o_s3_ws     (s3_ws)
    );

    bcwf_region #(
        .MAX_WINDOW    (MAX_WINDOW),
        .POSITION_BITS (POSITION_BITS)
    ) u_region (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s3          (s3),
        .i_ws          (s3_ws),
        .i_len         (r_len),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_count       (fifo_count)
    );

endmodule

`default_nettype wire

@@ verif/base_composition_window_filter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base_composition_window_filter_test
// Streams sequence bytes through the window filter under random stalls on
// both sides. A software copy of the window counting, scoring and region
// merging predicts every reported region, which is checked field by field.
// ----------------------------------------------------------------------------

module base_composition_window_filter_test;
    import bcwf_pkg::*;

    localparam int WIN_MAX       = MAX_WINDOW_DEF;
    localparam int ITEM_TARGET   = 450;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 150;
    localparam logic [7:0] BASE_CHARS [NUM_BASES] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};

    typedef struct {
        logic [OUT_W-1:0] region_start;
        logic [OUT_W-1:0] region_end;
        logic             region_valid;
        logic             stream_done;
    } region_t;

    class region_tracker;
        logic [REG_W-1:0] win_len_reg;
        logic [REG_W-1:0] threshold;
        logic [REG_W-1:0] query_count [NUM_BASES];
        int unsigned      win_count [NUM_BASES];
        logic [1:0]       history [WIN_MAX];
        int unsigned      wr_ptr;
        int unsigned      fill;
        logic [OUT_W-1:0] pos;
        bit               open;
        logic [OUT_W-1:0] open_start;
        logic [OUT_W-1:0] open_end;
        region_t          regions_due [$];
        int unsigned      errors;

        function new();
            win_len_reg = REG_W'(1);
            threshold = '0;
            foreach (query_count[k]) query_count[k] = '0;
            foreach (history[k]) history[k] = CODE_A;
            wr_ptr = 0;
            errors = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            foreach (win_count[k]) win_count[k] = 0;
            fill = 0;
            pos = '0;
            open = 1'b0;
            open_start = '0;
            open_end = '0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [REG_W-1:0] val);
            case (idx)
                REG_WINDOW_LENGTH:   win_len_reg = val;
                REG_SCORE_THRESHOLD: threshold = val;
                REG_QUERY_COUNT_A:   query_count[CODE_A] = val;
                REG_QUERY_COUNT_C:   query_count[CODE_C] = val;
                REG_QUERY_COUNT_G:   query_count[CODE_G] = val;
                REG_QUERY_COUNT_T:   query_count[CODE_T] = val;
                default: ;
            endcase
        endfunction

        // one accepted byte: update the window and queue any region it reports
        function void take_byte(logic [7:0] ch, logic eos);
            int unsigned      len;
            int unsigned      score;
            logic [1:0]       code;
            logic [1:0]       old;
            logic [OUT_W-1:0] ws;
            logic [OUT_W-1:0] gap;
            bit               closed;
            region_t          r;
            len = 32'(win_len_reg);
            if (len == 0) len = 1;
            if (len > WIN_MAX) len = WIN_MAX;
            case (ch)
                CHAR_C:  code = CODE_C;
                CHAR_G:  code = CODE_G;
                CHAR_T:  code = CODE_T;
                default: code = CODE_A;
            endcase
            closed = 1'b0;
            r = '{region_start: '0, region_end: '0, region_valid: 1'b0, stream_done: 1'b0};
            // the oldest byte leaves once the window is full
            if (fill >= len) begin
                old = history[(wr_ptr + WIN_MAX - len) % WIN_MAX];
                if (win_count[old] > 0) win_count[old]--;
            end
            history[wr_ptr] = code;
            wr_ptr = (wr_ptr + 1) % WIN_MAX;
            win_count[code]++;
            if (fill < WIN_MAX) fill++;
            if (fill >= len) begin
                ws = pos + 1 - len;
                score = 0;
                for (int k = 0; k < NUM_BASES; k++)
                    score += (win_count[k] < 32'(query_count[k])) ? win_count[k]
                                                                  : 32'(query_count[k]);
                gap = ws - open_end;
                if (score >= 32'(threshold)) begin
                    if (!open) begin
                        open = 1'b1;
                        open_start = ws;
                        open_end = ws + 1;
                    end else begin
                        open_end = ws;
                    end
                end else if (open && gap > len) begin
                    closed = 1'b1;
                    r.region_start = open_start;
                    r.region_end = open_end;
                    r.region_valid = 1'b1;
                    open = 1'b0;
                end
            end
            pos = pos + 1;
            if (eos) begin
                if (!closed && open) begin
                    r.region_start = open_start;
                    r.region_end = open_end;
                    r.region_valid = 1'b1;
                end
                r.stream_done = 1'b1;
                regions_due.push_back(r);
                clear_stream();
            end else if (closed) begin
                regions_due.push_back(r);
            end
        endfunction

        function void compare_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_region(region_t got);
            region_t want;
            if (regions_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual start %0h end %0h valid %0b done %0b",
                         $time, got.region_start, got.region_end, got.region_valid, got.stream_done);
                errors++;
                return;
            end
            want = regions_due.pop_front();
            compare_field("region_start", want.region_start, got.region_start);
            compare_field("region_end", want.region_end, got.region_end);
            compare_field("region_valid", 32'(want.region_valid), 32'(got.region_valid));
            compare_field("stream_done", 32'(want.stream_done), 32'(got.stream_done));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [REG_W-1:0]      i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;    // [7:0] base_char
    logic                  s_axis_tlast = 1'b0;  // end_of_stream
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [2*OUT_W-1:0]    m_axis_tdata;         // [31:0] region_start, [63:32] region_end
    logic                  m_axis_tuser;         // region_valid
    logic                  m_axis_tlast;         // stream_done

    region_tracker tracker = new();
    int unsigned   items_sent = 0;
    bit            steady = 1'b0;
    bit            long_hold = 1'b0;

    base_composition_window_filter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin : result_monitor
        region_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.region_start = m_axis_tdata[OUT_W-1:0];
            got.region_end = m_axis_tdata[2*OUT_W-1:OUT_W];
            got.region_valid = m_axis_tuser;
            got.stream_done = m_axis_tlast;
            tracker.check_region(got);
        end
    end

    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] ch, input logic eos);
        if (!steady && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ch;
        s_axis_tlast <= eos;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.take_byte(ch, eos);
        items_sent++;
    endtask

    // also covers bytes that report nothing but are still in the pipeline
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (tracker.regions_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_filter(input int unsigned len, thr, qa, qc, qg, qt);
        logic [REG_W-1:0]      vals [6];
        logic [CFG_ADDR_W-1:0] regs [6];
        vals = '{REG_W'(len), REG_W'(thr), REG_W'(qa), REG_W'(qc), REG_W'(qg), REG_W'(qt)};
        regs = '{REG_WINDOW_LENGTH, REG_SCORE_THRESHOLD, REG_QUERY_COUNT_A,
                 REG_QUERY_COUNT_C, REG_QUERY_COUNT_G, REG_QUERY_COUNT_T};
        for (int k = 0; k < 6; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_addr <= regs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            tracker.set_reg(regs[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_text(input string s, input logic eos_on_last);
        for (int k = 0; k < s.len(); k++)
            send_byte(s[k], eos_on_last && (k == s.len() - 1));
    endtask

    // mostly the preferred base, some other bases and a few arbitrary bytes
    function automatic logic [7:0] pick_char(input logic [1:0] pref);
        if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) return BASE_CHARS[pref];
        return BASE_CHARS[$urandom_range(0, 3)];
    endfunction

    function automatic int unsigned pick_query(input int unsigned len);
        if ($urandom_range(0, 9) == 0) return WIN_MAX;
        return $urandom_range(0, len);
    endfunction

    initial begin : stimulus
        int unsigned len;
        int unsigned slen;
        int unsigned left;
        int unsigned nstreams;
        int unsigned rand_start;
        logic [1:0]  pref;
        bit          last_open;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: unit window and zero threshold, every window hits
        send_byte(CHAR_A, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(CHAR_T, 1'b1);

        // zero length acts as one; gap close, reopen, region open at stream end
        wait_idle();
        program_filter(0, 1, 1, 0, 0, 0);
        send_text("ACCC", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CHAR_G, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CHAR_T, 1'b1);

        // stream ends before the first window fills
        wait_idle();
        program_filter(4, 3, 1, 1, 1, 1);
        send_text("AC", 1'b1);
        send_text("ACGTACGTAAAAAA", 1'b0);

        // window length changed inside a stream
        wait_idle();
        program_filter(2, 2, 1, 1, 1, 1);
        send_text("CGTA", 1'b1);

        // largest query counts, every window hits
        wait_idle();
        program_filter(3, 3, WIN_MAX, WIN_MAX, WIN_MAX, WIN_MAX);
        pref = 2'($urandom_range(0, 3));
        for (int k = 0; k < 12; k++)
            send_byte(pick_char(pref), k == 11);

        // length above the maximum is clamped, no window fills
        wait_idle();
        program_filter(2047, 1000, WIN_MAX, 0, 0, 0);
        for (int k = 0; k < 20; k++)
            send_byte(CHAR_A, k == 19);

        // results pile up behind a stalled receiver until the input stalls
        wait_idle();
        program_filter(1, 0, 0, 0, 0, 0);
        long_hold = 1'b1;
        repeat (40) send_byte(8'($urandom_range(0, 255)), 1'b1);

        rand_start = items_sent;
        last_open = 1'b0;
        len = 1;
        while (items_sent - rand_start < ITEM_TARGET) begin
            if (!steady) begin
                wait_idle();
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
                                                  : $urandom_range(1, 16);
                program_filter(len, $urandom_range(0, len), pick_query(len), pick_query(len),
                               pick_query(len), pick_query(len));
            end
            nstreams = $urandom_range(1, 3);
            for (int s = 0; s < nstreams && items_sent - rand_start < ITEM_TARGET; s++) begin
                slen = $urandom_range(1, 3 * len + 24);
                left = ITEM_TARGET - (items_sent - rand_start);
                if (slen > left) slen = left;
                last_open = (s == nstreams - 1) && ($urandom_range(0, 3) == 0);
                pref = 2'($urandom_range(0, 3));
                for (int k = 0; k < slen; k++) begin
                    if ($urandom_range(0, 9) == 0) pref = 2'($urandom_range(0, 3));
                    if (!steady && $urandom_range(0, 199) == 0) wait_idle();
                    send_byte(pick_char(pref), (k == slen - 1) && !last_open);
                end
                if (items_sent - rand_start >= ITEM_TARGET - 120) steady = 1'b1;
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.regions_due.size() == 0) begin
            $display("base_composition_window_filter_test OK");
        end else begin
            $display("base_composition_window_filter_test NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("base_composition_window_filter_test NOT OK");
        $finish;
    end

endmodule
